/* rtl/core/bts_pkg.sv */
// ----------------------------------------------------------------------------
// bts_pkg
// shared constants, register indexes and types of the breakout backtester
// ----------------------------------------------------------------------------
package bts_pkg;

  localparam int DEF_WINDOW_DEPTH = 16384;
  localparam int DEF_PRICE_BITS   = 24;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 40;

  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STOP    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CAPITAL = 2'd2;

  localparam logic [14:0] RST_WINDOW  = 15'd500;
  localparam logic [15:0] RST_STOP    = 16'd1311;
  localparam logic [39:0] RST_CAPITAL = 40'd10000000;

  localparam logic [1:0] MODE_FLAT  = 2'd0;
  localparam logic [1:0] MODE_LONG  = 2'd1;
  localparam logic [1:0] MODE_SHORT = 2'd2;

  localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;

  // channel extremes from the window scan
  typedef struct packed {
    logic [31:0] chan_hi;
    logic [31:0] chan_lo;
  } scan_res_t;

endpackage

/* rtl/core/bts_ram.sv */
// ----------------------------------------------------------------------------
// bts_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module bts_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/bts_div.sv */
// ----------------------------------------------------------------------------
// bts_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bts_div #(
  parameter int NUM_BITS = 64,
  parameter int DEN_BITS = 48
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output logic                done,
  output logic [NUM_BITS-1:0] quot
);

  localparam int CNT_BITS = $clog2(NUM_BITS + 1);

  logic [NUM_BITS-1:0] q_r, q_nxt;
  logic [DEN_BITS:0]   rem_r, rem_nxt;
  logic [DEN_BITS-1:0] den_r;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [DEN_BITS:0]   trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[DEN_BITS-1:0], q_r[NUM_BITS-1]};
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      cnt_nxt  = CNT_BITS'(NUM_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt   = {q_r[NUM_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[NUM_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

/* rtl/core/bts_scan.sv */
// ----------------------------------------------------------------------------
// bts_scan
// bar history rings, write of each bar and channel high/low scan
// ----------------------------------------------------------------------------
module bts_scan
  import bts_pkg::*;
#(
  parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  parameter int PRICE_BITS   = DEF_PRICE_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [PRICE_BITS-1:0]           wr_high,
  input  logic [PRICE_BITS-1:0]           wr_low,
  input  logic                            start,
  input  logic [$clog2(WINDOW_DEPTH):0]   len,
  output logic                            done,
  output scan_res_t                       res
);

  localparam int AW = $clog2(WINDOW_DEPTH);

  logic [AW-1:0]   wptr_r;
  logic [AW-1:0]   raddr_r;
  logic [AW:0]     left_r;
  logic            issue_r, rvld_r, busy_r, done_r;
  logic [PRICE_BITS-1:0] rd_hi, rd_lo;
  logic [31:0]     hi_r, lo_r;

  bts_ram #(.WIDTH(PRICE_BITS), .DEPTH(WINDOW_DEPTH)) u_high (
    .clk(clk), .we(wr_en), .waddr(wptr_r), .wdata(wr_high),
    .raddr(raddr_r), .rdata(rd_hi)
  );

  bts_ram #(.WIDTH(PRICE_BITS), .DEPTH(WINDOW_DEPTH)) u_low (
    .clk(clk), .we(wr_en), .waddr(wptr_r), .wdata(wr_low),
    .raddr(raddr_r), .rdata(rd_lo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      busy_r  <= 1'b0;
      issue_r <= 1'b0;
      rvld_r  <= 1'b0;
      done_r  <= 1'b0;
      left_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (wr_en) begin
        wptr_r <= wptr_r + 1'b1;
      end
      rvld_r <= issue_r;
      if (start) begin
        busy_r  <= 1'b1;
        issue_r <= 1'b1;
        left_r  <= len;
        raddr_r <= wptr_r - 1'b1;
        hi_r    <= '0;
        lo_r    <= '1;
      end else if (busy_r) begin
        if (issue_r) begin
          raddr_r <= raddr_r - 1'b1;
          left_r  <= left_r - 1'b1;
          if (left_r == (AW+1)'(1)) begin
            issue_r <= 1'b0;
          end
        end
        if (rvld_r) begin
          if (32'(rd_hi) > hi_r) hi_r <= 32'(rd_hi);
          if (32'(rd_lo) < lo_r) lo_r <= 32'(rd_lo);
        end
        if (!issue_r && !rvld_r) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done        = done_r;
  assign res.chan_hi = hi_r;
  assign res.chan_lo = lo_r;

endmodule

/* rtl/core/breakout_trailing_stop_backtest_unit.sv */
// ----------------------------------------------------------------------------
// breakout_trailing_stop_backtest_unit
// channel breakout backtester with trailing stop, one bar per transfer
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  in      | input     | in_valid, in_stall, bar fields, next_open, last_bar
//  out     | output    | out_valid, out_stall, position, cash, equity, score
//  cfg     | input     | cfg_we, cfg_index, cfg_data
//
// a warm-up or zero fill bar goes straight to the equity update; a bar with an
// open position first checks the trailing stop and exits when it fires; a flat
// bar scans window_length ring entries, and enters through a 64-step divide
// on a breakout; a scored last bar uses the same divider again. reset is
// synchronous and clears all control state; rings need no clearing. a result
// waits in the output register while the next bar may already transfer in.
// ----------------------------------------------------------------------------
module breakout_trailing_stop_backtest_unit
  import bts_pkg::*;
#(
  parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  parameter int PRICE_BITS   = DEF_PRICE_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [PRICE_BITS-1:0]    in_bar_high,
  input  logic [PRICE_BITS-1:0]    in_bar_low,
  input  logic [PRICE_BITS-1:0]    in_bar_close,
  input  logic [PRICE_BITS-1:0]    in_next_open,
  input  logic                     in_last_bar,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_position_mode,
  output logic signed [31:0]       out_share_count,
  output logic signed [47:0]       out_cash_balance,
  output logic signed [47:0]       out_equity_value,
  output logic signed [47:0]       out_max_drawdown,
  output logic signed [31:0]       out_score,
  output logic                     out_score_valid,
  output logic                     out_warming_up,
  output logic                     out_end_of_run
);

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int LW = AW + 1;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SCAN   = 4'd1;
  localparam logic [3:0] ST_ENTDIV = 4'd2;
  localparam logic [3:0] ST_ENTMUL = 4'd3;
  localparam logic [3:0] ST_TRAIL  = 4'd4;
  localparam logic [3:0] ST_EXIT   = 4'd5;
  localparam logic [3:0] ST_EQMUL  = 4'd6;
  localparam logic [3:0] ST_EQ     = 4'd7;
  localparam logic [3:0] ST_DD     = 4'd8;
  localparam logic [3:0] ST_SCDIV  = 4'd9;
  localparam logic [3:0] ST_SCORE  = 4'd10;
  localparam logic [3:0] ST_OUT    = 4'd11;
  localparam logic [3:0] ST_STOPM  = 4'd12;

  logic [14:0] win_r;
  logic [15:0] stop_r;
  logic [39:0] cap_r;

  logic [3:0]  st_r;
  logic [LW-1:0] seen_r;
  logic        stepped_r;
  logic [1:0]  mode_r;
  logic signed [47:0] cash_r;
  logic signed [31:0] shares_r;
  logic [31:0] lbest_r, sbest_r;
  logic signed [47:0] peak_r, wdd_r;

  logic [PRICE_BITS-1:0] bh_r, bl_r, cl_r, nx_r;
  logic        last_r, warm_r;
  logic [LW-1:0] len_r;

  logic signed [63:0] prod_r;
  logic signed [47:0] eq_r;
  logic signed [48:0] profit_r;
  logic        neg_r, entry_short_r, stop_hit_r;
  logic [63:0] num_r;
  logic signed [31:0] sc_r;
  logic        sv_r;

  logic        obuf_v_r;
  logic [1:0]  o_mode_r;
  logic signed [31:0] o_sh_r, o_score_r;
  logic signed [47:0] o_cash_r, o_eq_r, o_dd_r;
  logic        o_sv_r, o_warm_r, o_end_r;

  logic        scan_done, div_start, div_done;
  scan_res_t   scan_res;
  logic [63:0] div_quot;
  logic [47:0] div_den;
  logic [LW-1:0] len_c;
  logic        accept;
  logic [31:0] cl_w, nx_w, lb_w, sb_w;

  function automatic logic signed [47:0] sat48(input logic signed [65:0] v);
    if (v > 66'(MAX48)) return MAX48;
    if (v < 66'(MIN48)) return MIN48;
    return v[47:0];
  endfunction

  function automatic logic signed [63:0] clampp(input logic signed [63:0] p);
    if (p > 64'sd1125899906842624) return 64'sd1125899906842624;
    if (p < -64'sd1125899906842624) return -64'sd1125899906842624;
    return p;
  endfunction

  assign cl_w = 32'(cl_r);
  assign nx_w = 32'(nx_r);
  assign lb_w = (cl_w > lbest_r) ? cl_w : lbest_r;
  assign sb_w = (cl_w < sbest_r) ? cl_w : sbest_r;

  always_comb begin
    if (win_r == '0) begin
      len_c = LW'(1);
    end else if (32'(win_r) > 32'(WINDOW_DEPTH)) begin
      len_c = LW'(WINDOW_DEPTH);
    end else begin
      len_c = LW'(win_r);
    end
  end

  assign in_stall   = (st_r != ST_IDLE);
  assign accept     = in_valid && !in_stall;

  logic scan_go_r;
  bts_scan #(.WINDOW_DEPTH(WINDOW_DEPTH), .PRICE_BITS(PRICE_BITS)) u_scan (
    .clk(clk), .rst_n(rst_n), .wr_en(st_r == ST_OUT && !obuf_v_r),
    .wr_high(bh_r), .wr_low(bl_r), .start(scan_go_r), .len(len_r),
    .done(scan_done), .res(scan_res)
  );

  logic div_go_r;
  assign div_start = div_go_r;
  assign div_den   = (st_r == ST_ENTDIV) ? 48'(nx_r) : 48'(-wdd_r);
  bts_div #(.NUM_BITS(64), .DEN_BITS(48)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(num_r), .den(div_den),
    .done(div_done), .quot(div_quot)
  );

  logic signed [63:0] qs;
  logic signed [63:0] amt;
  always_comb begin
    qs  = neg_r ? -$signed(div_quot) : $signed(div_quot);
    amt = (qs > 64'sd2147483647) ? 64'sd2147483647 :
          (qs < -64'sd2147483648) ? -64'sd2147483648 : qs;
    if (entry_short_r) begin
      amt = (-amt > 64'sd2147483647) ? 64'sd2147483647 : -amt;
    end
  end

  // quotient already carries the 16 fraction bits
  logic [63:0] sq, mag;
  always_comb begin
    sq  = div_quot;
    mag = sq;
    if (sq[63:31] != '0) begin
      mag = neg_r ? 64'h8000_0000 : 64'h7FFF_FFFF;
    end else if (neg_r) begin
      mag = -mag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= RST_WINDOW; stop_r <= RST_STOP; cap_r <= RST_CAPITAL;
      st_r <= ST_IDLE; seen_r <= '0; stepped_r <= 1'b0; mode_r <= MODE_FLAT;
      cash_r <= 48'(RST_CAPITAL); shares_r <= '0; lbest_r <= '0; sbest_r <= '0;
      peak_r <= '0; wdd_r <= '0; obuf_v_r <= 1'b0; scan_go_r <= 1'b0;
      div_go_r <= 1'b0;
    end else begin
      scan_go_r <= 1'b0;
      div_go_r  <= 1'b0;
      if (obuf_v_r && !out_stall) obuf_v_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_WINDOW:  win_r <= cfg_data[14:0];
          CFG_STOP:    stop_r <= cfg_data[15:0];
          CFG_CAPITAL: begin
            cap_r <= cfg_data[39:0];
            if (!stepped_r) cash_r <= 48'(cfg_data[39:0]);
          end
          default: ;
        endcase
      end
      case (st_r)
        ST_IDLE: begin
          if (accept) begin
            bh_r <= in_bar_high; bl_r <= in_bar_low; cl_r <= in_bar_close;
            nx_r <= in_next_open; last_r <= in_last_bar;
            stepped_r <= 1'b1;
            len_r <= len_c;
            warm_r <= (seen_r < len_c);
            if (seen_r < len_c || in_next_open == '0) begin
              st_r <= ST_EQMUL;
            end else if (mode_r == MODE_FLAT) begin
              scan_go_r <= 1'b1;
              st_r <= ST_SCAN;
            end else begin
              st_r <= ST_TRAIL;
            end
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            if (cl_w > scan_res.chan_hi || cl_w < scan_res.chan_lo) begin
              entry_short_r <= !(cl_w > scan_res.chan_hi);
              neg_r <= cash_r[47];
              num_r <= {16'd0, cash_r[47] ? 48'(-cash_r) : 48'(cash_r)};
              div_go_r <= 1'b1;
              st_r <= ST_ENTDIV;
            end else begin
              st_r <= ST_EQMUL;
            end
          end
        end
        ST_ENTDIV: begin
          if (div_done) begin
            shares_r <= 32'(amt);
            prod_r <= clampp(64'(amt) * $signed({1'b0, nx_w}));
            if (entry_short_r) begin
              mode_r <= MODE_SHORT; sbest_r <= nx_w;
            end else begin
              mode_r <= MODE_LONG; lbest_r <= nx_w;
            end
            st_r <= ST_ENTMUL;
          end
        end
        ST_ENTMUL: begin
          cash_r <= sat48(66'(cash_r) - 66'(prod_r));
          st_r <= ST_EQMUL;
        end
        ST_TRAIL: begin
          lbest_r <= (mode_r == MODE_LONG) ? lb_w : lbest_r;
          sbest_r <= (mode_r == MODE_SHORT) ? sb_w : sbest_r;
          if (mode_r == MODE_LONG) begin
            stop_hit_r <= ({16'd0, cl_w, 16'd0} <
                           64'(lb_w) * 64'(17'h10000 - 17'(stop_r)));
          end else begin
            stop_hit_r <= ({16'd0, cl_w, 16'd0} >
                           64'(sb_w) * 64'(17'h10000 + 17'(stop_r)));
          end
          prod_r <= clampp(64'(shares_r) * $signed({1'b0, nx_w}));
          st_r <= ST_STOPM;
        end
        ST_STOPM: begin
          st_r <= stop_hit_r ? ST_EXIT : ST_EQMUL;
        end
        ST_EXIT: begin
          cash_r <= sat48(66'(cash_r) + 66'(prod_r));
          shares_r <= '0;
          mode_r <= MODE_FLAT;
          st_r <= ST_EQMUL;
        end
        ST_EQMUL: begin
          prod_r <= clampp(64'(shares_r) * $signed({1'b0, cl_w}));
          st_r <= ST_EQ;
        end
        ST_EQ: begin
          eq_r <= sat48(66'(cash_r) + 66'(prod_r));
          profit_r <= 49'(sat48(66'(cash_r) + 66'(prod_r))) - 49'(cap_r);
          st_r <= ST_DD;
        end
        ST_DD: begin
          logic signed [47:0] pk;
          logic signed [47:0] un;
          pk = peak_r;
          if (!warm_r) begin
            if (profit_r > 49'(peak_r)) pk = sat48(66'(profit_r));
            un = sat48(66'(eq_r) - 66'(pk) - 66'(cap_r));
            peak_r <= pk;
            if (un < wdd_r) wdd_r <= un;
          end
          st_r <= ST_SCORE;
        end
        ST_SCORE: begin
          if (last_r && wdd_r != '0) begin
            neg_r <= profit_r[48];
            num_r <= {profit_r[48] ? 48'(-profit_r) : 48'(profit_r), 16'd0};
            div_go_r <= 1'b1;
            st_r <= ST_SCDIV;
          end else begin
            sc_r <= '0;
            sv_r <= 1'b0;
            st_r <= ST_OUT;
          end
        end
        ST_SCDIV: begin
          if (div_done) begin
            sc_r <= 32'(mag);
            sv_r <= 1'b1;
            st_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!obuf_v_r) begin
            obuf_v_r <= 1'b1;
            o_mode_r <= mode_r; o_sh_r <= shares_r; o_cash_r <= cash_r;
            o_eq_r <= eq_r; o_dd_r <= wdd_r; o_warm_r <= warm_r;
            o_end_r <= last_r; o_score_r <= sc_r; o_sv_r <= sv_r;
            if (seen_r < LW'(WINDOW_DEPTH)) seen_r <= seen_r + 1'b1;
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid         = obuf_v_r;
  assign out_position_mode = o_mode_r;
  assign out_share_count   = o_sh_r;
  assign out_cash_balance  = o_cash_r;
  assign out_equity_value  = o_eq_r;
  assign out_max_drawdown  = o_dd_r;
  assign out_score         = o_score_r;
  assign out_score_valid   = o_sv_r;
  assign out_warming_up    = o_warm_r;
  assign out_end_of_run    = o_end_r;

endmodule
